>>> rtl/gbwp_pkg.sv
// Shared types, constants and the G-code modal group table of the word parser.
`default_nettype none

package gbwp_pkg;

  // Queue between the parser and the output stage.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Value limits.
  localparam logic [30:0] IntMax   = 31'h7FFF_FFFF;
  localparam logic [24:0] LineMax  = 25'd16777215;
  localparam logic [24:0] LineNone = 25'h1FF_FFFF;
  localparam logic [3:0]  NoGroup  = 4'd15;
  localparam logic [2:0]  FracMax  = 3'd6;
  localparam int unsigned GGroups  = 15;
  localparam int unsigned MGroups  = 11;

  // Error codes.
  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_CHAR     = 4'd1,
    ERR_UNCLOSED = 4'd2,
    ERR_NEG      = 4'd3,
    ERR_G_UNK    = 4'd4,
    ERR_G_DUP    = 4'd5,
    ERR_G_NEG    = 4'd6,
    ERR_G_BIG    = 4'd7,
    ERR_M_UNK    = 4'd8,
    ERR_M_DUP    = 4'd9,
    ERR_M_NEG    = 4'd10,
    ERR_M_BIG    = 4'd11
  } err_e;

  // Parser states, one-hot.
  typedef enum logic [13:0] {
    ST_START   = 14'b00000000000001,
    ST_SLASH   = 14'b00000000000010,
    ST_NLET    = 14'b00000000000100,
    ST_NDIG    = 14'b00000000001000,
    ST_BETWEEN = 14'b00000000010000,
    ST_LETTER  = 14'b00000000100000,
    ST_CMT0    = 14'b00000001000000,
    ST_CMT     = 14'b00000010000000,
    ST_CMT_M   = 14'b00000100000000,
    ST_CMT_S   = 14'b00001000000000,
    ST_CMT_G   = 14'b00010000000000,
    ST_SIGN    = 14'b00100000000000,
    ST_INT     = 14'b01000000000000,
    ST_FRAC    = 14'b10000000000000
  } state_e;

  // One queue entry: a finished word, an end of block, or both.
  typedef struct packed {
    logic        is_eob;
    logic        has_word;
    logic [6:0]  letter;
    logic        negative;
    logic [30:0] int_part;
    logic [19:0] frac_value;
    logic [2:0]  frac_digits;
    logic [9:0]  command_code;
    logic [3:0]  modal_group;
    logic [3:0]  word_err;
    logic [3:0]  sum_err;
    logic [24:0] line_number;
    logic        slash_flag;
    logic        message_flag;
  } entry_t;

  // Modal group of a G code given in tenths.
  function automatic logic [3:0] g_group(input logic [9:0] t);
    logic [3:0] g;
    case (t)
      10'd0, 10'd10, 10'd20, 10'd30, 10'd320, 10'd330, 10'd382,
      10'd800, 10'd810, 10'd820, 10'd830, 10'd840, 10'd850,
      10'd860, 10'd870, 10'd880, 10'd890: g = 4'd1;
      10'd40, 10'd100, 10'd280, 10'd300, 10'd520, 10'd530,
      10'd920, 10'd921, 10'd922, 10'd923: g = 4'd0;
      10'd170, 10'd180, 10'd190: g = 4'd2;
      10'd200, 10'd210: g = 4'd6;
      10'd400, 10'd410, 10'd420: g = 4'd7;
      10'd430, 10'd490: g = 4'd8;
      10'd500, 10'd960, 10'd970: g = 4'd14;
      10'd540, 10'd550, 10'd560, 10'd570, 10'd580, 10'd590,
      10'd591, 10'd592, 10'd593: g = 4'd12;
      10'd610, 10'd611, 10'd640: g = 4'd13;
      10'd900, 10'd910: g = 4'd3;
      10'd930, 10'd940: g = 4'd5;
      10'd980, 10'd990: g = 4'd10;
      default: g = NoGroup;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gbwp_front.sv
// Character parser: accepts line characters, tracks words and pushes finished entries.
`default_nettype none

module gbwp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            in_eob_i,
  input  wire logic [7:0]      in_char_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output gbwp_pkg::entry_t     q_data_o
);
  import gbwp_pkg::*;

  state_e      st_q, st_d;
  logic [6:0]  wl_q, wl_d;
  logic        sign_q, sign_d;
  logic [30:0] int_q, int_d;
  logic [19:0] frac_q, frac_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [3:0]  d1_q, d1_d, d2_q, d2_d;
  logic [GGroups-1:0] gused_q, gused_d;
  logic [MGroups-1:0] mused_q, mused_d;
  logic [24:0] line_q, line_d;
  logic        del_q, del_d, msg_q, msg_d;
  logic [3:0]  ferr_q, ferr_d;

  logic        acc;
  logic [7:0]  ch, up;
  logic [3:0]  dig;
  logic        is_dig, is_blank, is_let;
  logic [34:0] int_ext, int_nxt;
  logic [27:0] ln_ext, ln_nxt;

  // Word finish results.
  logic [3:0]  w_err, w_mg;
  logic [9:0]  w_cc;
  logic [GGroups-1:0] w_gset;
  logic [MGroups-1:0] w_mset;
  logic [10:0] g_sm;
  logic        g_rnd, g_big;
  logic        bad;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !q_full_i;
  assign ch         = in_char_i;
  assign dig        = ch[3:0];
  assign is_dig     = (ch >= "0") && (ch <= "9");
  assign is_blank   = (ch == 8'd32) || (ch == 8'd9);
  assign up         = ((ch >= "a") && (ch <= "z")) ? (ch - 8'd32) : ch;
  assign is_let     = ((up >= "A") && (up <= "D")) || ((up >= "F") && (up <= "M")) ||
                      ((up >= "P") && (up <= "Z"));

  // Saturating decimal accumulators, times ten by shift and add.
  assign int_ext = {4'b0, int_q};
  assign int_nxt = (int_ext << 3) + (int_ext << 1) + 35'(dig);
  assign ln_ext  = {4'b0, line_q[23:0]};
  assign ln_nxt  = (ln_ext << 3) + (ln_ext << 1) + 28'(dig);

  // G value in tenths from the integer part and the first two fraction digits.
  assign g_rnd = (d2_q >= 4'd5);
  assign g_sm  = ({4'b0, int_q[6:0]} << 3) + ({4'b0, int_q[6:0]} << 1) +
                 11'(d1_q) + 11'(g_rnd);
  assign g_big = (int_q >= 31'd100) || (g_sm >= 11'd1000);

  // Checks and modal lookup for the word now held.
  always_comb begin
    w_err  = ERR_NONE;
    w_cc   = '0;
    w_mg   = NoGroup;
    w_gset = '0;
    w_mset = '0;
    if (wl_q == 7'("D") || wl_q == 7'("H") || wl_q == 7'("L") || wl_q == 7'("T")) begin
      if (sign_q && int_q != '0) w_err = ERR_NEG;
    end else if (wl_q == 7'("F") || wl_q == 7'("P") || wl_q == 7'("Q") ||
                 wl_q == 7'("S")) begin
      if (sign_q && (int_q != '0 || frac_q != '0)) w_err = ERR_NEG;
    end else if (wl_q == 7'("G")) begin
      if (sign_q && (int_q != '0 || d1_q != '0 || g_rnd)) begin
        w_err = ERR_G_NEG;
      end else if (g_big) begin
        w_err = ERR_G_BIG;
      end else begin
        w_cc = g_sm[9:0];
        w_mg = g_group(g_sm[9:0]);
        if (w_mg == NoGroup) w_err = ERR_G_UNK;
        else if (gused_q[w_mg]) w_err = ERR_G_DUP;
        else w_gset[w_mg] = 1'b1;
      end
    end else if (wl_q == 7'("M")) begin
      if (sign_q && int_q != '0) begin
        w_err = ERR_M_NEG;
      end else if (int_q >= 31'd120) begin
        w_err = ERR_M_BIG;
        if (int_q < 31'd1000) w_cc = int_q[9:0];
      end else begin
        w_cc = int_q[9:0];
        case (int_q[6:0])
          7'd0, 7'd1, 7'd2, 7'd30, 7'd60, 7'd98, 7'd99: w_mg = 4'd4;
          7'd3, 7'd4, 7'd5: w_mg = 4'd7;
          7'd6: w_mg = 4'd6;
          7'd7, 7'd8, 7'd9: w_mg = 4'd8;
          7'd48, 7'd49: w_mg = 4'd9;
          default: w_mg = (int_q[6:0] >= 7'd100) ? 4'd10 : NoGroup;
        endcase
        if (w_mg == NoGroup) w_err = ERR_M_UNK;
        else if (mused_q[w_mg[3:0]]) w_err = ERR_M_DUP;
        else w_mset[w_mg] = 1'b1;
      end
    end
  end

  // Entry fields from the current word and line state.
  always_comb begin
    q_data_o              = '0;
    q_data_o.letter       = wl_q;
    q_data_o.negative     = sign_q;
    q_data_o.int_part     = int_q;
    q_data_o.frac_value   = frac_q;
    q_data_o.frac_digits  = fcnt_q;
    q_data_o.command_code = w_cc;
    q_data_o.modal_group  = w_mg;
    q_data_o.word_err     = w_err;
    q_data_o.line_number  = line_q;
    q_data_o.slash_flag   = del_q;
    q_data_o.message_flag = msg_q;
    q_data_o.is_eob       = in_eob_i;
    // A word left open by an earlier error is dropped, not emitted.
    q_data_o.has_word     = (ferr_q == ERR_NONE) && ((st_q == ST_INT) || (st_q == ST_FRAC));
    q_data_o.sum_err      = ferr_q;
    if (ferr_q == ERR_NONE) begin
      if (q_data_o.has_word) q_data_o.sum_err = w_err;
      else if (st_q != ST_START && st_q != ST_NDIG && st_q != ST_BETWEEN) begin
        q_data_o.sum_err = ERR_UNCLOSED;
      end
    end
  end

  // Next state for one accepted character or end of block.
  always_comb begin
    st_d = st_q; wl_d = wl_q; sign_d = sign_q; int_d = int_q; frac_d = frac_q;
    fcnt_d = fcnt_q; d1_d = d1_q; d2_d = d2_q; gused_d = gused_q; mused_d = mused_q;
    line_d = line_q; del_d = del_q; msg_d = msg_q; ferr_d = ferr_q;
    q_push_o = 1'b0;
    bad      = 1'b0;
    if (acc && in_eob_i) begin
      q_push_o = 1'b1;
      st_d = ST_START; wl_d = '0; sign_d = 1'b0; int_d = '0; frac_d = '0; fcnt_d = '0;
      d1_d = '0; d2_d = '0; gused_d = '0; mused_d = '0; line_d = LineNone;
      del_d = 1'b0; msg_d = 1'b0; ferr_d = ERR_NONE;
    end else if (acc && ferr_q == ERR_NONE) begin
      case (st_q)
        ST_START, ST_SLASH, ST_NDIG, ST_BETWEEN: begin
          if (is_blank) begin
            st_d = st_q;
          end else if (st_q == ST_NDIG && is_dig) begin
            line_d = (ln_nxt > 28'(LineMax)) ? LineMax : ln_nxt[24:0];
          end else if ((st_q == ST_START || st_q == ST_SLASH) && (ch == "N" || ch == "n")) begin
            line_d = '0;
            st_d   = ST_NLET;
          end else if (st_q == ST_START && ch == "/") begin
            del_d = 1'b1;
            st_d  = ST_SLASH;
          end else if (is_let) begin
            wl_d = up[6:0]; sign_d = 1'b0; int_d = '0; frac_d = '0; fcnt_d = '0;
            d1_d = '0; d2_d = '0; st_d = ST_LETTER;
          end else if (ch == "(") begin
            st_d = ST_CMT0;
          end else begin
            bad = 1'b1;
          end
        end
        ST_NLET: begin
          if (is_dig) begin
            line_d = 25'(dig);
            st_d   = ST_NDIG;
          end else if (!is_blank) begin
            bad = 1'b1;
          end
        end
        ST_LETTER, ST_SIGN: begin
          if (st_q == ST_LETTER && is_blank) begin
            st_d = st_q;
          end else if (st_q == ST_LETTER && (ch == "+" || ch == "-")) begin
            sign_d = (ch == "-");
            st_d   = ST_SIGN;
          end else if (is_dig) begin
            int_d = 31'(dig);
            st_d  = ST_INT;
          end else if (ch == ".") begin
            st_d = ST_FRAC;
          end else begin
            bad = 1'b1;
          end
        end
        ST_INT, ST_FRAC: begin
          if (is_dig) begin
            if (st_q == ST_INT) begin
              int_d = (int_nxt > 35'(IntMax)) ? IntMax : int_nxt[30:0];
            end else if (fcnt_q < FracMax) begin
              frac_d = (frac_q << 3) + (frac_q << 1) + 20'(dig);
              fcnt_d = fcnt_q + 3'd1;
              if (fcnt_q == 3'd0) d1_d = dig;
              if (fcnt_q == 3'd1) d2_d = dig;
            end
          end else if (st_q == ST_INT && ch == ".") begin
            st_d = ST_FRAC;
          end else if (is_blank) begin
            st_d = st_q;
          end else if (is_let || ch == "(") begin
            q_push_o = 1'b1;
            gused_d  = gused_q | w_gset;
            mused_d  = mused_q | w_mset;
            if (w_err != ERR_NONE) begin
              ferr_d = w_err;
              st_d   = ST_BETWEEN;
            end else if (is_let) begin
              wl_d = up[6:0]; sign_d = 1'b0; int_d = '0; frac_d = '0; fcnt_d = '0;
              d1_d = '0; d2_d = '0; st_d = ST_LETTER;
            end else begin
              st_d = ST_CMT0;
            end
          end else begin
            bad = 1'b1;
          end
        end
        ST_CMT0, ST_CMT, ST_CMT_M, ST_CMT_S, ST_CMT_G: begin
          if (ch == ")") begin
            st_d = ST_BETWEEN;
          end else if (st_q == ST_CMT || is_blank) begin
            st_d = st_q;
          end else if (st_q == ST_CMT0 && (ch == "M" || ch == "m")) begin
            st_d = ST_CMT_M;
          end else if (st_q == ST_CMT_M && (ch == "S" || ch == "s")) begin
            st_d = ST_CMT_S;
          end else if (st_q == ST_CMT_S && (ch == "G" || ch == "g")) begin
            st_d = ST_CMT_G;
          end else begin
            if (st_q == ST_CMT_G && ch == ",") msg_d = 1'b1;
            st_d = ST_CMT;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) ferr_d = ERR_CHAR;
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_START; wl_q <= '0; sign_q <= 1'b0; int_q <= '0; frac_q <= '0;
      fcnt_q <= '0; d1_q <= '0; d2_q <= '0; gused_q <= '0; mused_q <= '0;
      line_q <= LineNone; del_q <= 1'b0; msg_q <= 1'b0; ferr_q <= ERR_NONE;
    end else begin
      st_q <= st_d; wl_q <= wl_d; sign_q <= sign_d; int_q <= int_d; frac_q <= frac_d;
      fcnt_q <= fcnt_d; d1_q <= d1_d; d2_q <= d2_d; gused_q <= gused_d;
      mused_q <= mused_d; line_q <= line_d; del_q <= del_d; msg_q <= msg_d;
      ferr_q <= ferr_d;
    end
  end

  // An end of block always returns the parser to the start of a line.
  a_eob_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_eob_i |=> st_q == ST_START && ferr_q == ERR_NONE)
    else $error("parser not reset after end of block");

  // Once an error is latched, it holds until the end of block.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ferr_q != ERR_NONE && !(acc && in_eob_i) |=> ferr_q == $past(ferr_q))
    else $error("first error changed inside a line");

  // Nothing is pushed while an error blocks the line, except the summary.
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ferr_q != ERR_NONE && q_push_o |-> in_eob_i)
    else $error("word pushed after an error");

endmodule

`default_nettype wire

>>> rtl/gbwp_queue.sv
// Short first-in first-out queue between the parser and the output stage.
`default_nettype none

module gbwp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  gbwp_pkg::entry_t      push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output gbwp_pkg::entry_t      pop_data_o
);
  import gbwp_pkg::*;

  entry_t          mem_q [QDepth];
  logic [QAw-1:0]  wr_q, rd_q;
  logic [QAw:0]    cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
    end
  end

  // The fill count stays within the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAw+1)'(QDepth))
    else $error("queue count out of range");

  // Pointers stay apart by exactly the fill count.
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[QAw-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/gbwp_back.sv
// Output stage: holds one entry and sends its word row, its summary row, or both.
`default_nettype none

module gbwp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  gbwp_pkg::entry_t     q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_last_o,
  output logic [111:0]         out_data_o
);
  import gbwp_pkg::*;

  entry_t cur_q;
  logic   vld_q, word_q;
  logic   hs, beat_last;

  assign hs          = vld_q && out_ready_i;
  assign beat_last   = word_q ? !cur_q.is_eob : 1'b1;
  assign q_pop_o     = !q_empty_i && (!vld_q || (hs && beat_last));
  assign out_valid_o = vld_q;
  assign out_last_o  = !word_q;

  // Row fields: the word row, or the summary with blank word fields.
  always_comb begin
    out_data_o = '0;
    out_data_o[104:80] = cur_q.line_number;
    out_data_o[105]    = cur_q.slash_flag;
    out_data_o[106]    = cur_q.message_flag;
    if (word_q) begin
      out_data_o[6:0]   = cur_q.letter;
      out_data_o[7]     = cur_q.negative;
      out_data_o[38:8]  = cur_q.int_part;
      out_data_o[58:39] = cur_q.frac_value;
      out_data_o[61:59] = cur_q.frac_digits;
      out_data_o[71:62] = cur_q.command_code;
      out_data_o[75:72] = cur_q.modal_group;
      out_data_o[79:76] = cur_q.word_err;
    end else begin
      out_data_o[75:72] = NoGroup;
      out_data_o[79:76] = cur_q.sum_err;
    end
  end

  // Current entry and which of its rows is on offer.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      word_q <= 1'b0;
    end else if (q_pop_o) begin
      vld_q  <= 1'b1;
      word_q <= q_data_i.has_word;
    end else if (hs) begin
      if (beat_last) vld_q <= 1'b0;
      else word_q <= 1'b0;
    end
  end

  // A word row followed by its summary leads straight to the summary.
  a_word_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs && word_q && cur_q.is_eob |=> vld_q && !word_q)
    else $error("summary row lost after word row");

  // A summary row never reports a modal group.
  a_sum_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !word_q |-> out_data_o[75:72] == NoGroup && out_data_o[6:0] == '0)
    else $error("summary row carries word fields");

endmodule

`default_nettype wire

>>> rtl/gcode_block_word_parser_top.sv
// Top level of the G-code block word parser.
//
//  channel | dir | tdata                                | tuser/tlast
//  s_axis  | in  | [7:0] character                      | tlast = end of block (op)
//  m_axis  | out | letter..message_flag, 107 bits in 112 | tlast = summary row (kind)
//
// One character is taken every cycle while the four-entry queue has room;
// the parser updates its registered state for each accepted character.
// The output stage sends one row per cycle while a row waits and m_axis_tready is
// high; an end of block that closes a number gives a word row, then a summary row.
// Reset returns the parser to the start of a line with no line number.
// A stalled output fills the queue, after which s_axis_tready drops.
`default_nettype none

module gcode_block_word_parser_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] character
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [6:0] letter, [7] negative, [38:8] int_part, [58:39] frac_value,
  // [61:59] frac_digits, [71:62] command_code, [75:72] modal_group,
  // [79:76] error_code, [104:80] line_number, [105] slash flag,
  // [106] message_flag, [111:107] zero
  output logic [111:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  import gbwp_pkg::*;

  entry_t push_data, pop_data;
  logic   push, full, pop, empty;

  gbwp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_eob_i   (s_axis_tlast),
    .in_char_i  (s_axis_tdata),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  gbwp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  gbwp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> bench/gbwp_word_checker.sv
// Prediction and checking of the word parser output rows.
`default_nettype none

module gbwp_word_checker
  import gbwp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [7:0]   s_tdata_i,
  input  wire logic         s_tlast_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [111:0] m_tdata_i,
  input  wire logic         m_tlast_i,
  output int                fail_count_o,
  output int                rows_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit           summary;
    logic [111:0] word;
  } row_t;

  localparam int NumFields = 12;
  localparam int FieldLo[NumFields] = '{0, 7, 8, 39, 59, 62, 72, 76, 80, 105, 106, 107};
  localparam int FieldW[NumFields]  = '{7, 1, 31, 20, 3, 10, 4, 4, 25, 1, 1, 5};
  localparam string FieldName[NumFields] = '{"letter", "negative", "int_part",
    "frac_value", "frac_digits", "command_code", "modal_group", "error_code",
    "line_number", "slash_flag", "message_flag", "padding"};

  // G codes in tenths and their modal groups.
  localparam int GCodeCnt = 58;
  localparam int GTenths[GCodeCnt] = '{0, 10, 20, 30, 40, 100, 170, 180, 190, 200, 210,
    280, 300, 320, 330, 382, 400, 410, 420, 430, 490, 500, 520, 530, 540, 550, 560,
    570, 580, 590, 591, 592, 593, 610, 611, 640, 800, 810, 820, 830, 840, 850, 860,
    870, 880, 890, 900, 910, 920, 921, 922, 923, 930, 940, 960, 970, 980, 990};
  localparam int GGrp[GCodeCnt] = '{1, 1, 1, 1, 0, 0, 2, 2, 2, 6, 6, 0, 0, 1, 1, 1,
    7, 7, 7, 8, 8, 14, 0, 0, 12, 12, 12, 12, 12, 12, 12, 12, 12, 13, 13, 13, 1, 1, 1,
    1, 1, 1, 1, 1, 1, 1, 3, 3, 0, 0, 0, 0, 5, 5, 14, 14, 10, 10};

  // Parser state mirror.
  state_e     pstate;
  logic [6:0] cur_letter;
  bit         minus_seen;
  longint     int_acc;
  int         frac_acc;
  int         frac_cnt;
  bit [15:0]  g_used;
  bit [15:0]  m_used;
  int         line_num;
  bit         del_mark;
  bit         msg_seen;
  err_e       line_err;

  row_t rows_due[$];

  function automatic int g_lookup(int tenths);
    for (int i = 0; i < GCodeCnt; i++) begin
      if (GTenths[i] == tenths) return GGrp[i];
    end
    return NoGroup;
  endfunction

  function automatic int m_lookup(int n);
    if (n <= 2 || n == 30 || n == 60 || n == 98 || n == 99) return 4;
    if (n >= 3 && n <= 5) return 7;
    if (n == 6) return 6;
    if (n >= 7 && n <= 9) return 8;
    if (n == 48 || n == 49) return 9;
    if (n >= 100 && n < 120) return 10;
    return NoGroup;
  endfunction

  function automatic logic [6:0] address_of(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if ((u >= "A" && u <= "D") || (u >= "F" && u <= "M") || (u >= "P" && u <= "Z"))
      return u[6:0];
    return 7'd0;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'd32 || c == 8'd9;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_line();
    pstate = ST_START;
    cur_letter = '0;
    minus_seen = 0;
    int_acc = 0;
    frac_acc = 0;
    frac_cnt = 0;
    g_used = '0;
    m_used = '0;
    line_num = -1;
    del_mark = 0;
    msg_seen = 0;
    line_err = ERR_NONE;
  endfunction

  function automatic void push_row(bit summary, logic [6:0] l, bit neg, longint ip,
                                   int fv, int fd, int cc, int mg, err_e ec);
    row_t r;
    logic [24:0] ln;
    ln = line_num[24:0];
    r.summary = summary;
    r.word = {5'd0, msg_seen, del_mark, ln, ec, mg[3:0], cc[9:0], fd[2:0], fv[19:0],
              ip[30:0], neg, l};
    rows_due.push_back(r);
  endfunction

  function automatic void start_word(logic [6:0] l);
    cur_letter = l;
    minus_seen = 0;
    int_acc = 0;
    frac_acc = 0;
    frac_cnt = 0;
    pstate = ST_LETTER;
  endfunction

  // Closes the current word, queues its row and returns the error it raised.
  function automatic err_e close_word();
    int cc, mg, d1, d2, t;
    longint tenths;
    err_e e;
    cc = 0;
    mg = NoGroup;
    e = ERR_NONE;
    case (cur_letter)
      "D", "H", "L", "T": if (minus_seen && int_acc != 0) e = ERR_NEG;
      "F", "P", "Q", "S": if (minus_seen && (int_acc != 0 || frac_acc != 0)) e = ERR_NEG;
      "G": begin
        d1 = 0;
        d2 = 0;
        t = frac_acc;
        if (frac_cnt == 1) d1 = t % 10;
        else if (frac_cnt >= 2) begin
          for (int i = frac_cnt; i > 2; i--) t = t / 10;
          d2 = t % 10;
          d1 = (t / 10) % 10;
        end
        tenths = int_acc * 10 + d1 + (d2 >= 5 ? 1 : 0);
        if (minus_seen && tenths != 0) e = ERR_G_NEG;
        else if (tenths >= 1000) e = ERR_G_BIG;
        else begin
          cc = int'(tenths);
          mg = g_lookup(cc);
          if (mg == NoGroup) e = ERR_G_UNK;
          else if (g_used[mg]) e = ERR_G_DUP;
          else g_used[mg] = 1;
        end
      end
      "M": begin
        if (minus_seen && int_acc != 0) e = ERR_M_NEG;
        else if (int_acc >= 120) begin
          e = ERR_M_BIG;
          if (int_acc < 1000) cc = int'(int_acc);
        end else begin
          cc = int'(int_acc);
          mg = m_lookup(cc);
          if (mg == NoGroup) e = ERR_M_UNK;
          else if (m_used[mg]) e = ERR_M_DUP;
          else m_used[mg] = 1;
        end
      end
      default: ;
    endcase
    if (e != ERR_NONE && line_err == ERR_NONE) line_err = e;
    push_row(0, cur_letter, minus_seen, int_acc, frac_acc, frac_cnt, cc, mg, e);
    pstate = ST_BETWEEN;
    return e;
  endfunction

  // One line character.
  function automatic void take_char(logic [7:0] c);
    logic [6:0] l;
    bit bad;
    int v;
    l = address_of(c);
    bad = 0;
    case (pstate)
      ST_START, ST_SLASH, ST_NDIG, ST_BETWEEN: begin
        if (blank(c)) return;
        if (pstate == ST_NDIG && digit(c)) begin
          v = line_num * 10 + (c - "0");
          line_num = v > 16777215 ? 16777215 : v;
        end else if ((pstate == ST_START || pstate == ST_SLASH) && (c == "N" || c == "n")) begin
          line_num = 0;
          pstate = ST_NLET;
        end else if (pstate == ST_START && c == "/") begin
          del_mark = 1;
          pstate = ST_SLASH;
        end else if (l != 0) start_word(l);
        else if (c == "(") pstate = ST_CMT0;
        else bad = 1;
      end
      ST_NLET: begin
        if (blank(c)) return;
        if (digit(c)) begin
          line_num = c - "0";
          pstate = ST_NDIG;
        end else bad = 1;
      end
      ST_LETTER, ST_SIGN: begin
        if (pstate == ST_LETTER && blank(c)) return;
        if (pstate == ST_LETTER && (c == "+" || c == "-")) begin
          minus_seen = (c == "-");
          pstate = ST_SIGN;
        end else if (digit(c)) begin
          int_acc = c - "0";
          pstate = ST_INT;
        end else if (c == ".") pstate = ST_FRAC;
        else bad = 1;
      end
      ST_INT, ST_FRAC: begin
        if (digit(c)) begin
          if (pstate == ST_INT) begin
            int_acc = int_acc * 10 + (c - "0");
            if (int_acc > 64'd2147483647) int_acc = 2147483647;
          end else if (frac_cnt < 6) begin
            frac_acc = frac_acc * 10 + (c - "0");
            frac_cnt++;
          end
        end else if (pstate == ST_INT && c == ".") pstate = ST_FRAC;
        else if (blank(c)) return;
        else if (l != 0 || c == "(") begin
          if (close_word() == ERR_NONE) begin
            if (l != 0) start_word(l);
            else pstate = ST_CMT0;
          end
        end else bad = 1;
      end
      default: begin
        // Comment states: watch for an opening MSG followed by a comma.
        if (c == ")") pstate = ST_BETWEEN;
        else if (pstate == ST_CMT || blank(c)) return;
        else if (pstate == ST_CMT0 && (c == "M" || c == "m")) pstate = ST_CMT_M;
        else if (pstate == ST_CMT_M && (c == "S" || c == "s")) pstate = ST_CMT_S;
        else if (pstate == ST_CMT_S && (c == "G" || c == "g")) pstate = ST_CMT_G;
        else begin
          if (pstate == ST_CMT_G && c == ",") msg_seen = 1;
          pstate = ST_CMT;
        end
      end
    endcase
    if (bad && line_err == ERR_NONE) line_err = ERR_CHAR;
  endfunction

  // End of block: close an open number, then queue the summary.
  function automatic void take_eob();
    if (line_err == ERR_NONE) begin
      if (pstate == ST_INT || pstate == ST_FRAC) void'(close_word());
      else if (pstate != ST_START && pstate != ST_NDIG && pstate != ST_BETWEEN)
        line_err = ERR_UNCLOSED;
    end
    push_row(1, 7'd0, 0, 0, 0, 0, 0, NoGroup, line_err);
    clear_line();
  endfunction

  // Compare finished rows first, then predict from the accepted character or end of block.
  always @(posedge clk_i) begin
    row_t r;
    logic [111:0] fe, fa;
    if (!rst_ni) begin
      clear_line();
      rows_due.delete();
      rows_pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row tlast=%0b tdata=%h", $realtime, m_tlast_i, m_tdata_i);
          fail_count_o++;
        end else begin
          r = rows_due.pop_front();
          if (r.summary != m_tlast_i) begin
            $display("%0t: kind expected %0b actual %0b", $realtime, r.summary, m_tlast_i);
            fail_count_o++;
          end
          for (int i = 0; i < NumFields; i++) begin
            fe = (r.word >> FieldLo[i]) & ((112'd1 << FieldW[i]) - 1);
            fa = (m_tdata_i >> FieldLo[i]) & ((112'd1 << FieldW[i]) - 1);
            if (fe != fa) begin
              $display("%0t: %s expected %0d actual %0d", $realtime, FieldName[i], fe, fa);
              fail_count_o++;
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tlast_i) take_eob();
        else if (line_err == ERR_NONE) take_char(s_tdata_i);
      end
      rows_pending_o = rows_due.size();
    end
  end

endmodule

`default_nettype wire

>>> bench/gcode_block_word_parser_top_tb.sv
// Stimulus, flow control and verdict for the G-code word parser.
`default_nettype none

module gcode_block_word_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count;
  int           rows_pending;
  int           chars_sent;
  int           burst_left;
  int           hold_asks;
  int           hold_seen;
  bit           drained;
  longint       cycle_count;

  gcode_block_word_parser_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  gbwp_word_checker checker_u (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .fail_count_o(fail_count), .rows_pending_o(rows_pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: rotates through three stall patterns, plus long hold-offs on request.
  initial begin
    int cyc;
    cyc = 0;
    hold_seen = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
      end
      case ((cyc / 256) % 3)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one character or end of block; may idle between bursts of random length.
  task automatic send_word(bit eob, logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eob;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line(string txt);
    for (int i = 0; i < txt.len(); i++) send_word(0, txt[i]);
    send_word(1, 8'($urandom_range(0, 255)));
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Mostly well-formed random line, with occasional noise.
  function automatic string random_line();
    string s, w;
    string g_codes[10] = '{"0", "1", "17", "54.1", "92.3", "64", "38.2", "90", "0.15", "43"};
    string m_codes[8] = '{"3", "5", "8", "30", "48", "6", "100", "2"};
    string letters = "ABCDFGHIJKLMPQRSTUVWXYZxyzgm";
    int nw;
    s = "";
    if ($urandom_range(0, 9) == 0) s = "/";
    if ($urandom_range(0, 2) == 0) s = {s, "N", digits($urandom_range(1, 9)), " "};
    nw = $urandom_range(0, 5);
    for (int i = 0; i < nw; i++) begin
      case ($urandom_range(0, 11))
        0: s = {s, "G", g_codes[$urandom_range(0, 9)]};
        1: s = {s, "M", m_codes[$urandom_range(0, 7)]};
        2: s = {s, ($urandom_range(0, 1) ? "(MSG, hi)" : "( msg ,x)")};
        3: s = {s, "(tool ", digits(2), ")"};
        4: s = {s, string'(byte'($urandom_range(0, 255)))};
        default: begin
          w = string'(letters[$urandom_range(0, letters.len() - 1)]);
          case ($urandom_range(0, 3))
            0: w = {w, "-"};
            1: w = {w, "+"};
            default: ;
          endcase
          w = {w, digits($urandom_range(0, 9) == 0 ? 11 : $urandom_range(0, 3))};
          if ($urandom_range(0, 1)) w = {w, ".", digits($urandom_range(0, 8))};
          if (w.len() == 1 || w[w.len() - 1] == "-" || w[w.len() - 1] == "+")
            w = {w, digits(1)};
          s = {s, w};
        end
      endcase
      if ($urandom_range(0, 1)) s = {s, ($urandom_range(0, 3) == 0) ? "\t" : " "};
    end
    return s;
  endfunction

  initial begin
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 0;
    chars_sent = 0;
    burst_left = 0;
    hold_asks = 0;
    drained = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed lines: special cases and field extremes.
    send_line("/N12 G1 x-1.5 Y.25");
    send_line("n7G0.15M3 F-0 S-0.0");
    send_line("(MSG, hi)G90");
    send_line("X1.12345678 D2");
    send_line("M120 G-0.04");
    send_line("Z+ 3");
    send_line("A99999999999 T-2");
    send_line("N99999999");
    send_line("M6 M6");
    // Character zero inside a comment and outside one.
    send_word(0, "(");
    send_word(0, 8'h00);
    send_word(0, 8'hFF);
    send_word(0, ")");
    send_word(0, "X");
    send_word(0, "1");
    send_word(0, 8'h00);
    send_word(1, 8'h00);
    send_line("N");
    send_line("X-");
    send_line("(open");
    send_line("/");
    send_line("");
    send_line("E5");

    // Random lines, with a long receiver hold-off and a full drain along the way.
    while (chars_sent < 1500) begin
      if (hold_asks == 0 && chars_sent > 500) hold_asks = 1;
      if (!drained && chars_sent > 1000) begin
        drained = 1;
        s_axis_tvalid <= 0;
        @(negedge clk_i);
        wait (rows_pending == 0);
        @(posedge clk_i);
      end
      send_line(random_line());
    end
    s_axis_tvalid <= 0;

    @(negedge clk_i);
    wait (rows_pending == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
